### hdl/assert_macros.svh
// Assertion macros for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/hcbd_pkg.sv
// Types, codes and helpers for the chunked body decoder.
package hcbd_pkg;

   localparam int SIZE_WIDTH_DEF = 32;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   typedef enum logic [2:0] {
      PH_SIZE    = 3'd0,
      PH_SIZE_LF = 3'd1,
      PH_DATA    = 3'd2,
      PH_DATA_CR = 3'd3,
      PH_DATA_LF = 3'd4,
      PH_TRAILER = 3'd5,
      PH_HALTED  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE     = 2'd0,
      KIND_COMPLETE = 2'd1,
      KIND_MALFORM  = 2'd2
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic       start;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data;
   } result_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [7:0] diff;
      logic [4:0] res;
      diff = 8'h00;
      res  = 5'b0_0000;
      if (c inside {[8'h30:8'h39]}) begin
         diff = c - 8'h30;
         res  = {1'b1, diff[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
         diff = c - 8'h57;
         res  = {1'b1, diff[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
         diff = c - 8'h37;
         res  = {1'b1, diff[3:0]};
      end
      return res;
   endfunction

endpackage

### hdl/hcbd_in.sv
// Input word register of the chunked body decoder.
module hcbd_in (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,
   input  logic [7:0]          req_tdata,
   input  logic                advance,
   output hcbd_pkg::item_type  item
);
   import hcbd_pkg::*;

   logic       valid_ff, valid_in;
   logic       start_ff;
   logic [7:0] data_ff;
   logic       take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         start_ff <= req_tuser;
         data_ff  <= req_tdata;
      end
   end

   assign item = '{valid: valid_ff, start: start_ff, data: data_ff};

endmodule

### hdl/hcbd_core.sv
// Chunk parsing state machine: one input word per advance.
module hcbd_core #(
   parameter int SIZE_WIDTH = hcbd_pkg::SIZE_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  hcbd_pkg::item_type   item,
   output hcbd_pkg::result_type result
);
   import hcbd_pkg::*;

   phase_type             phase_ff, phase_in, phase_eff;
   logic [SIZE_WIDTH-1:0] size_ff, size_in, size_eff, size_dec;
   logic                  saw_ff, saw_in, saw_eff;
   logic [1:0]            trail_ff, trail_in, trail_eff, trail_inc;
   logic [4:0]            hex;
   logic                  too_big;

   // a start flag clears the state before the word is taken
   assign phase_eff = item.start ? PH_SIZE : phase_ff;
   assign size_eff  = item.start ? '0 : size_ff;
   assign saw_eff   = item.start ? 1'b0 : saw_ff;
   assign trail_eff = item.start ? 2'd0 : trail_ff;

   assign hex       = hex_decode(item.data);
   assign too_big   = |size_eff[SIZE_WIDTH-1:SIZE_WIDTH-4];
   assign size_dec  = size_eff - SIZE_WIDTH'(1);
   assign trail_inc = (trail_eff == 2'd3) ? 2'd3 : trail_eff + 2'd1;

   // next state
   always_comb begin
      phase_in = phase_eff;
      size_in  = size_eff;
      saw_in   = saw_eff;
      trail_in = trail_eff;
      case (phase_eff)
         PH_SIZE: begin
            if (item.data == CH_CR) begin
               phase_in = saw_eff ? PH_SIZE_LF : PH_HALTED;
            end else if (!hex[4] || too_big) begin
               phase_in = PH_HALTED;
            end else begin
               size_in = {size_eff[SIZE_WIDTH-5:0], hex[3:0]};
               saw_in  = 1'b1;
            end
         end
         PH_SIZE_LF: begin
            if (item.data != CH_LF) begin
               phase_in = PH_HALTED;
            end else begin
               saw_in = 1'b0;
               if (size_eff == '0) begin
                  phase_in = PH_TRAILER;
                  trail_in = 2'd0;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            size_in = size_dec;
            if (size_dec == '0) begin
               phase_in = PH_DATA_CR;
            end
         end
         PH_DATA_CR: begin
            phase_in = (item.data == CH_CR) ? PH_DATA_LF : PH_HALTED;
         end
         PH_DATA_LF: begin
            if (item.data != CH_LF) begin
               phase_in = PH_HALTED;
            end else begin
               phase_in = PH_SIZE;
               size_in  = '0;
               saw_in   = 1'b0;
            end
         end
         PH_TRAILER: begin
            trail_in = trail_inc;
            if (trail_inc == 2'd3) begin
               phase_in = PH_HALTED;
            end
         end
         default: begin
            phase_in = phase_eff;
         end
      endcase
   end

   // result word
   always_comb begin
      result = '{valid: 1'b0, kind: KIND_BYTE, data: 8'h00};
      case (phase_eff)
         PH_SIZE: begin
            if (item.data == CH_CR) begin
               if (!saw_eff) begin
                  result.valid = 1'b1;
                  result.kind  = KIND_MALFORM;
               end
            end else if (!hex[4] || too_big) begin
               result.valid = 1'b1;
               result.kind  = KIND_MALFORM;
            end
         end
         PH_SIZE_LF: begin
            result.valid = (item.data != CH_LF) || (size_eff == '0);
            result.kind  = (item.data != CH_LF) ? KIND_MALFORM : KIND_COMPLETE;
         end
         PH_DATA: begin
            result.valid = 1'b1;
            result.kind  = KIND_BYTE;
            result.data  = item.data;
         end
         PH_DATA_CR: begin
            result.valid = (item.data != CH_CR);
            result.kind  = KIND_MALFORM;
         end
         PH_DATA_LF: begin
            result.valid = (item.data != CH_LF);
            result.kind  = KIND_MALFORM;
         end
         PH_TRAILER: begin
            result.valid = (trail_inc == 2'd3);
            result.kind  = KIND_MALFORM;
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
      result.valid = result.valid && item.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIZE;
         size_ff  <= '0;
         saw_ff   <= 1'b0;
         trail_ff <= 2'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         size_ff  <= size_in;
         saw_ff   <= saw_in;
         trail_ff <= trail_in;
      end
   end

endmodule

### hdl/hcbd_out.sv
// Result word register of the chunked body decoder.
module hcbd_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  hcbd_pkg::result_type result,
   output logic                 free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [1:0]           rsp_tuser,
   output logic [7:0]           rsp_tdata
);
   import hcbd_pkg::*;

   logic       valid_ff, valid_in;
   kind_type   kind_ff;
   logic [7:0] data_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= result.kind;
         data_ff <= result.data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = data_ff;

endmodule

### hdl/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder.
//
// Usage: feed the raw chunked body one byte per word on the req_ channel.
// Set req_tuser (start of message) on the first byte of a body; it clears
// the decoder before that byte is taken. Each decoded body byte leaves on
// the rsp_ channel with kind 0; a zero-size chunk gives one kind 1 word
// (body complete); a framing error gives one kind 2 word (malformed), after
// which the decoder stays silent until the next start flag.
// Size lines, CR LF pairs and the first two trailing bytes produce nothing.
// Each result reaches rsp_ through the input register, then the result
// register. Throughput: one byte per cycle while rsp_tready stays high;
// the parsing state machine updates its state on every advance.
// Reset: synchronous, active high; drops any held words and returns the
// parser to expecting a size line.
// Stall: while rsp_tready is low with a result held, the input register
// holds its byte and req_tready drops once that register is full.
`include "assert_macros.svh"
module http_chunked_body_decoder #(
   parameter int SIZE_WIDTH = hcbd_pkg::SIZE_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_tuser,   // [0] start_of_message
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic [7:0] rsp_tdata    // [7:0] body_byte
);
   import hcbd_pkg::*;

   item_type   item;
   result_type result;
   logic       free;
   logic       advance;

   // advance the held byte whenever the result register can take a word
   assign advance = item.valid && free;

   hcbd_in u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item       (item)
   );

   hcbd_core #(
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   hcbd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && result.valid),
      .result     (result),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   `ASSERT_IMPL(a_kind_legal, clock, reset, rsp_tvalid, rsp_tuser <= KIND_MALFORM)
   `ASSERT_IMPL(a_status_no_byte, clock, reset, rsp_tvalid && rsp_tuser != KIND_BYTE, rsp_tdata == '0)
   `ASSERT_IMPL(a_no_advance_on_stall, clock, reset, rsp_tvalid && !rsp_tready, !advance)
   `ASSERT_NEXT(a_held_byte_stays, clock, reset, item.valid && !advance, item.valid)

endmodule

### test/http_chunked_body_decoder_checker.sv
// Checker that predicts and compares the result words of the chunked body decoder.
`timescale 1ns / 100ps
module http_chunked_body_decoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic       req_tuser,   // [0] start_of_message
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [1:0] rsp_tuser,   // [1:0] kind
   input  logic [7:0] rsp_tdata,   // [7:0] body_byte
   output int         error_count,
   output int         outstanding
);
   import hcbd_pkg::*;

   localparam int SW = SIZE_WIDTH_DEF;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] body;
   } decoded_type;

   decoded_type   decoded_fifo[$];
   phase_type     phase;
   logic [SW-1:0] remaining;
   logic          saw_digit;
   logic [1:0]    trailer_count;

   // {is_hex, value}
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      logic [7:0] folded;
      logic [7:0] value;
      folded = c | 8'h20;
      if (c >= 8'h30 && c <= 8'h39) begin
         value = c - 8'h30;
      end else if (folded >= 8'h61 && folded <= 8'h66) begin
         value = folded - 8'h57;
      end else begin
         return 5'b0_0000;
      end
      return {1'b1, value[3:0]};
   endfunction

   function automatic void flag_malformed();
      phase = PH_HALTED;
      decoded_fifo.push_back('{kind: KIND_MALFORM, body: 8'h00});
   endfunction

   function automatic void decode_byte(input logic start, input logic [7:0] c);
      logic [4:0] hex;
      hex = nibble_of(c);
      if (start) begin
         phase         = PH_SIZE;
         remaining     = '0;
         saw_digit     = 1'b0;
         trailer_count = 2'd0;
      end
      case (phase)
         PH_SIZE: begin
            if (c == CH_CR) begin
               if (!saw_digit) flag_malformed();
               else phase = PH_SIZE_LF;
            end else if (!hex[4] || remaining[SW-1 -: 4] != 4'h0) begin
               flag_malformed();
            end else begin
               remaining = {remaining[SW-5:0], hex[3:0]};
               saw_digit = 1'b1;
            end
         end
         PH_SIZE_LF: begin
            if (c != CH_LF) begin
               flag_malformed();
            end else begin
               saw_digit = 1'b0;
               if (remaining == '0) begin
                  phase         = PH_TRAILER;
                  trailer_count = 2'd0;
                  decoded_fifo.push_back('{kind: KIND_COMPLETE, body: 8'h00});
               end else begin
                  phase = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            remaining = remaining - SW'(1);
            if (remaining == '0) phase = PH_DATA_CR;
            decoded_fifo.push_back('{kind: KIND_BYTE, body: c});
         end
         PH_DATA_CR: begin
            if (c != CH_CR) flag_malformed();
            else phase = PH_DATA_LF;
         end
         PH_DATA_LF: begin
            if (c != CH_LF) begin
               flag_malformed();
            end else begin
               phase     = PH_SIZE;
               remaining = '0;
               saw_digit = 1'b0;
            end
         end
         PH_TRAILER: begin
            if (trailer_count != 2'd3) trailer_count++;
            if (trailer_count == 2'd3) flag_malformed();
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      decoded_type want;
      if (reset) begin
         phase         = PH_SIZE;
         remaining     = '0;
         saw_digit     = 1'b0;
         trailer_count = 2'd0;
         error_count   = 0;
         decoded_fifo.delete();
      end else begin
         // compare first so a stray word never meets a fresh prediction
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_fifo.size() == 0) begin
               $error("unexpected result word: kind %0d, body_byte 0x%02h",
                      rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want = decoded_fifo.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata !== want.body) begin
                  $error("body_byte: expected 0x%02h, got 0x%02h", want.body, rsp_tdata);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) decode_byte(req_tuser, req_tdata);
      end
      outstanding = decoded_fifo.size();
   end

endmodule

### test/http_chunked_body_decoder_tb.sv
// Testbench top: drives chunked bodies into the decoder and reports the verdict.
`timescale 1ns / 100ps
module http_chunked_body_decoder_tb;
   import hcbd_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic       req_tuser;    // [0] start_of_message
   logic [7:0] req_tdata;    // [7:0] data_byte
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [1:0] rsp_tuser;    // [1:0] kind
   logic [7:0] rsp_tdata;    // [7:0] body_byte

   int error_count;
   int outstanding;
   int send_idle_pct;
   int recv_idle_pct;
   int words_sent;

   // bytes of the message being built; the first one carries the start flag
   logic [7:0] stream_q[$];

   http_chunked_body_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   http_chunked_body_decoder_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver: drop ready at random, according to the current idle rate
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // hex digit of a nibble, upper or lower case at random
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   // Offer one word at a falling edge after a random gap; hold it until taken.
   task automatic send_word(input logic start, input logic [7:0] data);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_stream();
      int i;
      for (i = 0; i < stream_q.size(); i++) send_word(i == 0, stream_q[i]);
      stream_q.delete();
   endtask

   // Drop valid, wait for every predicted word, then let the pipeline settle.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic append_size_line(input logic [31:0] size, input int zeros);
      int digits;
      int i;
      digits = 1;
      for (i = 1; i < 8; i++) begin
         if ((size >> (4 * i)) != 0) digits = i + 1;
      end
      repeat (zeros) stream_q.push_back(8'h30);
      for (i = digits - 1; i >= 0; i--) stream_q.push_back(hex_char(size[4*i +: 4]));
      stream_q.push_back(CH_CR);
      stream_q.push_back(CH_LF);
   endtask

   // Well-formed body: 0..3 chunks, the zero chunk, then 0..4 trailing bytes.
   task automatic append_message();
      int chunks;
      int size;
      int i;
      chunks = $urandom_range(0, 3);
      for (i = 0; i < chunks; i++) begin
         size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
         append_size_line(size, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0);
         repeat (size) stream_q.push_back(8'($urandom_range(0, 255)));
         stream_q.push_back(CH_CR);
         stream_q.push_back(CH_LF);
      end
      append_size_line(0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0);
      repeat ($urandom_range(0, 4)) stream_q.push_back(8'($urandom_range(0, 255)));
   endtask

   // Size line too wide for the register, or a huge size cut short by the next start.
   task automatic append_wide_size();
      if ($urandom_range(0, 1)) begin
         stream_q.push_back(hex_char(4'($urandom_range(1, 15))));
         repeat ($urandom_range(8, 10)) stream_q.push_back(hex_char(4'($urandom_range(0, 15))));
         stream_q.push_back(CH_CR);
         stream_q.push_back(CH_LF);
      end else begin
         append_size_line({4'($urandom_range(1, 15)), 28'($urandom)}, $urandom_range(0, 3));
         repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // Time limit far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("timeout: %0d result words still expected", outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int round;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = 1'b0;
      req_tdata     = 8'h00;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      words_sent    = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (round = 0; round < 3; round++) begin
         case (round)
            0: begin
               send_idle_pct = 26;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         if (round == 0) begin
            // two extreme data bytes, completion, two quiet trailers, a third
            // that is malformed, then a byte the halted decoder ignores
            append_size_line(2, 0);
            stream_q.push_back(8'h00);
            stream_q.push_back(8'hFF);
            stream_q.push_back(CH_CR);
            stream_q.push_back(CH_LF);
            append_size_line(0, 0);
            stream_q.push_back(8'h78);
            stream_q.push_back(8'h79);
            stream_q.push_back(8'h7A);
            stream_q.push_back(8'h71);
            send_stream();
            // empty size line
            stream_q.push_back(CH_CR);
            send_stream();
            // non-hex character
            stream_q.push_back(8'h67);
            send_stream();
            // CR of a size line without its LF
            stream_q.push_back(8'h31);
            stream_q.push_back(CH_CR);
            stream_q.push_back(8'h31);
            send_stream();
            // ninth digit overflows the size register
            repeat (8) stream_q.push_back(8'h46);
            stream_q.push_back(8'h30);
            send_stream();
         end

         while (words_sent < (round + 1) * 500) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  append_message();
                  send_stream();
               end
               6, 7: begin
                  // corrupt one byte of an otherwise clean body
                  append_message();
                  stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom_range(0, 255));
                  send_stream();
               end
               8: begin
                  append_wide_size();
                  send_stream();
               end
               default: begin
                  repeat ($urandom_range(1, 8))
                     send_word($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
               end
            endcase
         end

         // hold the sender until every predicted word has come out
         wait_drained();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/hcbd_pkg.sv
hdl/hcbd_in.sv
hdl/hcbd_core.sv
hdl/hcbd_out.sv
hdl/http_chunked_body_decoder.sv
test/http_chunked_body_decoder_checker.sv
test/http_chunked_body_decoder_tb.sv
